@@ sv/lrpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpg_pkg
// Shared types, constants and the color wheel of the LED rainbow pattern
// generator.
// ----------------------------------------------------------------------------
package lrpg_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int CNT_W      = 7;   // holds a pixel count up to MAX_PIXELS
    localparam int PIX_W      = 6;   // pixel index width
    localparam int DIV_STEPS  = 9;   // bits of the dividend 256

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PIXELS);

    // Register indexes of the configuration port
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_COLOR = 2'd2;

    typedef enum logic [1:0] {
        MODE_RAINBOW = 2'd0,
        MODE_CYCLE   = 2'd1,
        MODE_CHASE   = 2'd2,
        MODE_WIPE    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;      // frame request taken
        logic div_step;   // one step of the 256 / count division
        logic pix_load;   // compute one pixel into the output register
        logic frame_end;  // advance the pattern counters
    } lrpg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;   // current division step is the final one
        logic out_free;   // output register can take a pixel this cycle
        logic pix_last;   // pixel being computed is the final one
    } lrpg_sts_t;

    // Color wheel: position 0..255 onto red-green-blue ramps in steps of 3
    function automatic rgb_t wheel(input logic [7:0] pos);
        rgb_t       c;
        logic [7:0] d;
        logic [7:0] t;
        begin
            if (pos < 8'd85) begin
                d = pos;
            end else if (pos < 8'd170) begin
                d = pos - 8'd85;
            end else begin
                d = pos - 8'd170;
            end
            t = 8'({d, 1'b0} + {1'b0, d});
            if (pos < 8'd85) begin
                c.red   = t;
                c.green = 8'd255 - t;
                c.blue  = 8'd0;
            end else if (pos < 8'd170) begin
                c.red   = 8'd255 - t;
                c.green = 8'd0;
                c.blue  = t;
            end else begin
                c.red   = 8'd0;
                c.green = t;
                c.blue  = 8'd255 - t;
            end
            return c;
        end
    endfunction

endpackage

@@ sv/lrpg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpg_ctrl
// Frame sequencer: takes a frame request, runs the step division, then
// issues one pixel per free output slot and closes the frame.
// ----------------------------------------------------------------------------
module lrpg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lrpg_pkg::lrpg_sts_t sts,
    output lrpg_pkg::lrpg_cmd_t cmd
);
    import lrpg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_RUN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.out_free)
                begin
                    cmd.pix_load = 1'b1;
                    if (sts.pix_last)
                    begin
                        cmd.frame_end = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/lrpg_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpg_datapath
// Configuration registers, pattern counters, step divider, pixel color
// logic and the output register.
// ----------------------------------------------------------------------------
module lrpg_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [23:0]                cfg_data,
    input  logic                       restart,
    input  lrpg_pkg::lrpg_cmd_t        cmd,
    output lrpg_pkg::lrpg_sts_t        sts,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lrpg_pkg::PIX_W-1:0] pixel_index,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue,
    output logic                       last_pixel
);
    import lrpg_pkg::*;

    // Configuration
    mode_t            mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [23:0]      color_reg;

    // Pattern counters
    logic [7:0]       offset_reg,   offset_next;
    logic [1:0]       phase_reg,    phase_next;
    logic [CNT_W-1:0] wpos_reg,     wpos_next;
    logic             wclr_reg,     wclr_next;

    // Divider and per-pixel walk
    logic [3:0]       div_cnt_reg;
    logic [CNT_W-2:0] div_rem_reg;
    logic [7:0]       div_quo_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [1:0]       mod3_reg;
    logic [7:0]       acc_q_reg;
    logic [CNT_W-2:0] acc_r_reg;

    // Output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_idx_reg;
    rgb_t             out_rgb_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] count_eff;
    logic [CNT_W:0]   rem_sh;
    logic             rem_ge;
    logic [CNT_W-1:0] acc_r_sum;
    logic [8:0]       chase_pos;
    logic [7:0]       chase_wpos;
    logic             wipe_lit;
    rgb_t             pix_rgb;
    logic [CNT_W:0]   wpos_inc;

    // Clamp the pixel count into 1..MAX_PIXELS
    always_comb
    begin
        if (count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (count_reg > MAX_COUNT)
        begin
            count_eff = MAX_COUNT;
        end
        else
        begin
            count_eff = count_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RAINBOW;
            count_reg <= CNT_W'(12);
            color_reg <= 24'hFF0000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= mode_t'(cfg_data[1:0]);
                REG_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                REG_COLOR: color_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Restoring division step of 256 by the count
    assign rem_sh = {1'b0, div_rem_reg, (div_cnt_reg == 4'(DIV_STEPS - 1))};
    assign rem_ge = (rem_sh >= {1'b0, count_eff});

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            div_cnt_reg <= 4'(DIV_STEPS - 1);
            div_rem_reg <= '0;
            div_quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - 4'd1;
            div_rem_reg <= rem_ge ? (CNT_W-1)'(rem_sh - {1'b0, count_eff})
                                  : (CNT_W-1)'(rem_sh);
            div_quo_reg <= {div_quo_reg[6:0], rem_ge};
        end
    end

    // Walk the pixels: index, index mod 3 and floor(p*256/count)
    assign acc_r_sum = {1'b0, acc_r_reg} + {1'b0, div_rem_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pix_reg   <= '0;
            mod3_reg  <= '0;
            acc_q_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (cmd.pix_load)
        begin
            pix_reg  <= pix_reg + PIX_W'(1);
            mod3_reg <= (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            if (acc_r_sum >= count_eff)
            begin
                acc_r_reg <= (CNT_W-1)'(acc_r_sum - count_eff);
                acc_q_reg <= acc_q_reg + div_quo_reg + 8'd1;
            end
            else
            begin
                acc_r_reg <= acc_r_sum[CNT_W-2:0];
                acc_q_reg <= acc_q_reg + div_quo_reg;
            end
        end
    end

    // Pixel color for the selected pattern
    assign chase_pos  = {3'b000, pix_reg} - {7'b0, phase_reg} + {1'b0, offset_reg};
    assign chase_wpos = (chase_pos >= 9'd255) ? 8'(chase_pos - 9'd255) : chase_pos[7:0];
    assign wipe_lit   = ({1'b0, pix_reg} < wpos_reg) != wclr_reg;

    always_comb
    begin
        pix_rgb = '0;
        case (mode_reg)
            MODE_RAINBOW: pix_rgb = wheel({2'b00, pix_reg} + offset_reg);
            MODE_CYCLE:   pix_rgb = wheel(acc_q_reg + offset_reg);
            MODE_CHASE:
            begin
                if (mod3_reg == phase_reg)
                begin
                    pix_rgb = wheel(chase_wpos);
                end
            end
            MODE_WIPE:
            begin
                if (wipe_lit)
                begin
                    pix_rgb = color_reg;
                end
            end
            default: pix_rgb = '0;
        endcase
    end

    assign sts.div_done = (div_cnt_reg == 4'd0);
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.pix_last = ({1'b0, pix_reg} + CNT_W'(1)) == count_eff;

    // Counter updates: clear on restart, advance at frame end
    assign wpos_inc = {1'b0, wpos_reg} + (CNT_W+1)'(1);

    always_comb
    begin
        offset_next = offset_reg;
        phase_next  = phase_reg;
        wpos_next   = wpos_reg;
        wclr_next   = wclr_reg;
        if (cmd.start && restart)
        begin
            offset_next = '0;
            phase_next  = '0;
            wpos_next   = '0;
            wclr_next   = 1'b0;
        end
        else if (cmd.frame_end)
        begin
            case (mode_reg)
                MODE_RAINBOW, MODE_CYCLE:
                begin
                    offset_next = offset_reg + 8'd1;
                end
                MODE_CHASE:
                begin
                    if (phase_reg >= 2'd2)
                    begin
                        phase_next  = '0;
                        offset_next = offset_reg + 8'd32;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
                MODE_WIPE:
                begin
                    if (wpos_inc >= {1'b0, count_eff})
                    begin
                        wpos_next = '0;
                        wclr_next = !wclr_reg;
                    end
                    else
                    begin
                        wpos_next = wpos_inc[CNT_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            phase_reg  <= '0;
            wpos_reg   <= '0;
            wclr_reg   <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            phase_reg  <= phase_next;
            wpos_reg   <= wpos_next;
            wclr_reg   <= wclr_next;
        end
    end

    // Output register: load a pixel, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.pix_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_load)
        begin
            out_idx_reg  <= pix_reg;
            out_rgb_reg  <= pix_rgb;
            out_last_reg <= sts.pix_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = out_idx_reg;
    assign red         = out_rgb_reg.red;
    assign green       = out_rgb_reg.green;
    assign blue        = out_rgb_reg.blue;
    assign last_pixel  = out_last_reg;

endmodule

@@ sv/led_rainbow_pattern_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_rainbow_pattern_generator_unit
// Emits one frame of LED strip colors per request: rainbow, rainbow cycle,
// theater chase rainbow or color wipe, one pixel per result.
// ----------------------------------------------------------------------------
//  Channel   Direction   Signals                                   Moves
//  in        in          in_valid/in_ready, restart                frame request
//  out       out         out_valid/out_ready, pixel_index, red,    one pixel
//                        green, blue, last_pixel
//  cfg       in          cfg_valid/cfg_ready, cfg_index, cfg_data  register write
//
//  A request is accepted, then the bit-serial restoring division of 256 by the
//  pixel count runs, then one pixel per cycle while the output does not stall.
//  A new request is taken only once the last pixel of the frame has gone into
//  the single output register. Output stalls hold the pixel walk in place.
//  Reset loads the default configuration and clears all pattern counters.
// ----------------------------------------------------------------------------
module led_rainbow_pattern_generator_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       restart,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lrpg_pkg::PIX_W-1:0] pixel_index,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue,
    output logic                       last_pixel,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [23:0]                cfg_data
);
    import lrpg_pkg::*;

    lrpg_cmd_t cmd;
    lrpg_sts_t sts;

    // Registers take writes at any time
    assign cfg_ready = 1'b1;

    lrpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lrpg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .restart     (restart),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel)
    );

`ifndef NO_ASSERTIONS
    // A taken request leaves the idle state
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while a frame was still open");

    // A new request only starts once the previous frame's pixels are all issued
    a_request_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || last_pixel)
        else $error("request accepted in the middle of a frame");

    // Within a frame, the next pixel follows at once with the next index
    a_pixel_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_pixel |=>
            out_valid && (pixel_index == $past(pixel_index) + 6'd1))
        else $error("pixel sequence broken within a frame");
`endif

endmodule

@@ tb/lrpg_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpg_frame_checker
// Watches the request, pixel and register channels of the LED rainbow pattern
// generator. Keeps its own copy of the registers and pattern counters, builds
// the expected pixels of each accepted frame request, and compares every
// accepted pixel field by field against the oldest expected pixel.
// ----------------------------------------------------------------------------
module lrpg_frame_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       restart,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [lrpg_pkg::PIX_W-1:0] pixel_index,
    input  logic [7:0]                 red,
    input  logic [7:0]                 green,
    input  logic [7:0]                 blue,
    input  logic                       last_pixel,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [23:0]                cfg_data,
    output int                         fail_count,
    output int                         pending,
    output int                         checked
);
    import lrpg_pkg::*;

    localparam logic [6:0]  RESET_LEN = 7'd12;
    localparam logic [23:0] RESET_RGB = 24'hFF0000;

    typedef struct packed {
        logic [PIX_W-1:0] index;
        rgb_t             color;
        logic             last;
    } pixel_t;

    pixel_t     pixel_q[$];

    // Register copy
    mode_t      mode;
    logic [6:0] strip_len;
    rgb_t       fill_rgb;

    // Pattern counters
    logic [7:0] hue_base;
    logic [1:0] chase_step;
    logic [6:0] wipe_edge;
    logic       wipe_off;

    int         errors = 0;
    int         seen   = 0;

    assign fail_count = errors;
    assign checked    = seen;

    // Map a wheel position onto the three color ramps
    function automatic rgb_t hue_to_rgb(input int unsigned pos);
        rgb_t        c;
        int unsigned h;
        int unsigned k;
        h = pos & 255;
        if (h < 85) begin
            c.red   = 8'(3 * h);
            c.green = 8'(255 - 3 * h);
            c.blue  = 8'd0;
        end else if (h < 170) begin
            k       = h - 85;
            c.red   = 8'(255 - 3 * k);
            c.green = 8'd0;
            c.blue  = 8'(3 * k);
        end else begin
            k       = h - 170;
            c.red   = 8'd0;
            c.green = 8'(3 * k);
            c.blue  = 8'(255 - 3 * k);
        end
        return c;
    endfunction

    // Queue the pixels of one frame, clearing the counters first on restart, then advance the running pattern
    task automatic build_frame(input logic clear_counters);
        int unsigned n;
        int unsigned p;
        pixel_t      px;
        n = strip_len;
        if (n < 1) n = 1;
        if (n > MAX_PIXELS) n = MAX_PIXELS;
        if (clear_counters) begin
            hue_base   = '0;
            chase_step = '0;
            wipe_edge  = '0;
            wipe_off   = 1'b0;
        end
        for (p = 0; p < n; p++) begin
            px.index = PIX_W'(p);
            px.color = '0;
            px.last  = (p == n - 1);
            case (mode)
                MODE_RAINBOW: px.color = hue_to_rgb(p + hue_base);
                MODE_CYCLE:   px.color = hue_to_rgb(p * 256 / n + hue_base);
                MODE_CHASE:
                begin
                    if (p % 3 == chase_step)
                        px.color = hue_to_rgb((p - chase_step + hue_base) % 255);
                end
                default:
                begin
                    if ((p < wipe_edge) != wipe_off) px.color = fill_rgb;
                end
            endcase
            pixel_q.push_back(px);
        end
        case (mode)
            MODE_RAINBOW, MODE_CYCLE: hue_base = hue_base + 8'd1;
            MODE_CHASE:
            begin
                if (chase_step >= 2'd2) begin
                    chase_step = '0;
                    hue_base   = hue_base + 8'd32;
                end else begin
                    chase_step = chase_step + 2'd1;
                end
            end
            default:
            begin
                // wrap also covers a boundary left past a shortened strip
                if (int'(wipe_edge) + 1 >= n) begin
                    wipe_edge = '0;
                    wipe_off  = ~wipe_off;
                end else begin
                    wipe_edge = wipe_edge + 7'd1;
                end
            end
        endcase
    endtask

    // Compare one accepted pixel with the oldest expected pixel
    task automatic check_pixel();
        pixel_t px;
        if (pixel_q.size() == 0) begin
            $error("unexpected pixel: pixel_index %0d with no frame pending", pixel_index);
            errors++;
        end else begin
            px = pixel_q.pop_front();
            seen++;
            if (pixel_index !== px.index) begin
                $error("pixel_index: expected %0d, got %0d", px.index, pixel_index);
                errors++;
            end
            if (red !== px.color.red) begin
                $error("red: expected %0d, got %0d", px.color.red, red);
                errors++;
            end
            if (green !== px.color.green) begin
                $error("green: expected %0d, got %0d", px.color.green, green);
                errors++;
            end
            if (blue !== px.color.blue) begin
                $error("blue: expected %0d, got %0d", px.color.blue, blue);
                errors++;
            end
            if (last_pixel !== px.last) begin
                $error("last_pixel: expected %0d, got %0d", px.last, last_pixel);
                errors++;
            end
        end
    endtask

    // Track register writes, pixels and frame requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode       = MODE_RAINBOW;
            strip_len  = RESET_LEN;
            fill_rgb   = RESET_RGB;
            hue_base   = '0;
            chase_step = '0;
            wipe_edge  = '0;
            wipe_off   = 1'b0;
            pixel_q.delete();
            pending   <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE:  mode      = mode_t'(cfg_data[1:0]);
                    REG_COUNT: strip_len = cfg_data[6:0];
                    REG_COLOR: fill_rgb  = cfg_data;
                    default:   ;
                endcase
            end
            if (out_valid && out_ready) check_pixel();
            if (in_valid && in_ready) build_frame(restart);
            pending <= pixel_q.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frame requests and register writes into the LED rainbow pattern
// generator with random gaps and output back-pressure, runs a directed set of
// corner frames followed by random register settings and request bursts, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import lrpg_pkg::*;

    localparam int          LIMIT       = 4_000_000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_TAIL  = 20;
    localparam int          TARGET      = 230;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic             restart   = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [PIX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last_pixel;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = REG_MODE;
    logic [23:0]      cfg_data  = '0;

    int               fail_count;
    int               pending;
    int               checked;

    int unsigned      cycle_cnt     = 0;
    int               frames_sent   = 0;
    int               restarts_sent = 0;
    int               reg_writes    = 0;
    bit               no_gaps       = 1'b0;
    bit               hold_req      = 1'b0;
    bit               hold_on       = 1'b0;

    led_rainbow_pattern_generator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    lrpg_frame_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $error("timeout after %0d cycles, %0d pixels still pending", LIMIT, pending);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(16, 40);
    endfunction

    // Output back-pressure, with one long hold-off on request
    initial
    begin
        int stall;
        forever begin
            if (hold_req) begin
                hold_on = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                hold_on  = 1'b0;
            end
            stall = pick_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Offer one frame request; valid stays high across back-to-back requests
    task automatic send_request(input logic clear);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= clear;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        frames_sent++;
        if (clear) restarts_sent++;
    endtask

    task automatic send_burst(input int n, input int clear_pct);
        for (int i = 0; i < n; i++)
            send_request($urandom_range(0, 99) < clear_pct);
    endtask

    // Drop the request and wait for every expected pixel plus the frame tail
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Write one register; call only while idle
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // Mode write with random upper bits
    task automatic write_mode(input mode_t m);
        logic [23:0] data;
        data      = 24'($urandom);
        data[1:0] = m;
        write_reg(REG_MODE, data);
    endtask

    // Count write with random upper bits
    task automatic write_count(input logic [6:0] n);
        logic [23:0] data;
        data      = 24'($urandom);
        data[6:0] = n;
        write_reg(REG_COUNT, data);
    endtask

    // Mostly short strips, some long, a few out of range
    function automatic logic [6:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 7'($urandom_range(1, 16));
        if (r < 88) return 7'($urandom_range(17, 64));
        if (r < 94) return 7'd64;
        if (r < 97) return 7'd0;
        return 7'($urandom_range(65, 127));
    endfunction

    // Stimulus and verdict
    initial
    begin
        int phase;
        phase = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // Default setup: rainbow on twelve pixels, with and without restart
        send_request(1'b0);
        send_request(1'b1);
        settle();

        // Rainbow cycle on the full strip, a single pixel and out-of-range counts
        write_mode(MODE_CYCLE);
        write_count(7'd64);
        send_request(1'b0);
        settle();
        write_count(7'd1);
        send_request(1'b0);
        settle();
        write_reg(REG_COUNT, 24'hFFFF80);
        send_request(1'b0);
        settle();
        write_count(7'd127);
        send_request(1'b1);
        settle();

        // Theater chase through a full phase wrap
        write_mode(MODE_CHASE);
        write_count(7'd10);
        send_request(1'b1);
        send_burst(3, 0);
        settle();

        // Color wipe: fill and clear, then shrink the strip under the boundary
        write_mode(MODE_WIPE);
        write_reg(REG_COLOR, 24'hFFFFFF);
        write_count(7'd5);
        send_request(1'b1);
        send_burst(6, 0);
        settle();
        write_count(7'd2);
        send_burst(2, 0);
        settle();

        // Black fill, a write to the unused index, and a mode change on kept counters
        write_reg(REG_COLOR, 24'h000000);
        write_reg(REG_UNUSED, 24'($urandom));
        send_request(1'b0);
        settle();
        write_mode(MODE_RAINBOW);
        send_request(1'b0);
        settle();

        // Random settings and request bursts
        while (frames_sent < TARGET) begin
            phase++;
            settle();
            no_gaps = (phase == 3);
            write_mode(mode_t'($urandom_range(0, 3)));
            if ($urandom_range(0, 99) < 70) write_count(pick_count());
            if ($urandom_range(0, 99) < 50) write_reg(REG_COLOR, 24'($urandom));
            // stall the receiver for a long stretch while requests keep coming
            if (phase == 5) begin
                hold_req = 1'b1;
                wait (hold_on);
            end
            send_burst($urandom_range(4, 16), 10);
        end
        settle();

        $display("Covered %0d frame requests (%0d with restart) and %0d register writes,",
                 frames_sent, restarts_sent, reg_writes);
        $display("with %0d pixels compared over all four patterns and a held-off receiver.",
                 checked);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
